[design/dep_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dep_pkg: shared types and constants of the double-ended priority queue
// Holds the request and result formats, the command codes and the control
// and status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dep_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Command codes of a request. Code 3 is unused and acts as a no-op.
    localparam logic [1:0] CMD_INSERT     = 2'd0;
    localparam logic [1:0] CMD_REMOVE_MAX = 2'd1;
    localparam logic [1:0] CMD_REMOVE_MIN = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic signed [31:0] max_value;
        logic signed [31:0] min_value;
        logic               is_empty;
        logic               insert_dropped;
        logic [6:0]         entry_count;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // latch key, start insert position, clear drop flag
        logic drop;      // with load: the insert is refused
        logic rd_prev;   // read the entry below the insert position
        logic shift;     // move the entry read one place up
        logic place;     // write the key at the insert position
        logic pop_max;   // drop the top entry, fetch the next one down
        logic pop_min;   // drop the bottom entry, fetch the next one up
        logic take_max;  // fetched entry becomes the maximum
        logic take_min;  // fetched entry becomes the minimum
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic one;
        logic j_zero;
        logic rd_gt_key;
    } t_dp_status;

endpackage
`default_nettype wire

[design/dep_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dep_datapath: entry storage and pointers of the priority queue
// Entries sit in ascending order in a circular memory. A head pointer marks
// the minimum, so removing the minimum is a pointer step, and inserts move
// larger entries up one place per step. Minimum and maximum are kept in
// registers.
// ----------------------------------------------------------------------------
module dep_datapath #(
    parameter int CAPACITY    = dep_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = dep_pkg::VALUE_WIDTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  dep_pkg::t_item       i_item,
    input  dep_pkg::t_dp_cmd     i_cmd,
    output dep_pkg::t_dp_status  o_status,
    output dep_pkg::t_result     o_result
);
    import dep_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];

    logic [AW-1:0]                 r_head, n_head;
    logic [CW-1:0]                 r_count, n_count;
    logic [AW-1:0]                 r_pos, n_pos;
    logic [CW-1:0]                 r_j, n_j;
    logic signed [VALUE_WIDTH-1:0] r_key, n_key;
    logic signed [VALUE_WIDTH-1:0] r_min, n_min;
    logic signed [VALUE_WIDTH-1:0] r_max, n_max;
    logic                          r_dropped, n_dropped;
    logic signed [VALUE_WIDTH-1:0] r_rd_data;

    logic [AW-1:0]                 w_tail;
    logic [AW-1:0]                 w_last2;
    logic [AW-1:0]                 w_rd_addr;
    logic                          w_we;
    logic [AW-1:0]                 w_wr_addr;
    logic signed [VALUE_WIDTH-1:0] w_wr_data;
    logic signed [VALUE_WIDTH-1:0] w_in_key;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] a);
        f_next = (a == AW'(CAPACITY - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] a);
        f_prev = (a == '0) ? AW'(CAPACITY - 1) : a - AW'(1);
    endfunction

    // Sums of a pointer and an offset stay below twice the capacity.
    function automatic logic [AW-1:0] f_wrap(input logic [SW-1:0] s);
        f_wrap = (s >= SW'(CAPACITY)) ? AW'(s - SW'(CAPACITY)) : AW'(s);
    endfunction

    always_comb begin
        w_in_key  = VALUE_WIDTH'(i_item.value);
        w_tail    = f_wrap(SW'(r_head) + SW'(r_count));
        w_last2   = f_wrap(SW'(r_head) + SW'(r_count) - SW'(2));

        if (i_cmd.rd_prev) begin
            w_rd_addr = f_prev(r_pos);
        end else if (i_cmd.pop_max) begin
            w_rd_addr = w_last2;
        end else begin
            w_rd_addr = f_next(r_head);
        end

        w_we      = i_cmd.shift | i_cmd.place;
        w_wr_addr = r_pos;
        w_wr_data = i_cmd.shift ? r_rd_data : r_key;

        n_head    = r_head;
        n_count   = r_count;
        n_pos     = r_pos;
        n_j       = r_j;
        n_key     = r_key;
        n_min     = r_min;
        n_max     = r_max;
        n_dropped = r_dropped;

        if (i_cmd.load) begin
            n_key     = w_in_key;
            n_pos     = w_tail;
            n_j       = r_count;
            n_dropped = i_cmd.drop;
        end
        if (i_cmd.shift) begin
            n_pos = f_prev(r_pos);
            n_j   = r_j - CW'(1);
        end
        if (i_cmd.place) begin
            n_count = r_count + CW'(1);
            if (r_count == '0) begin
                n_min = r_key;
                n_max = r_key;
            end else begin
                if (r_key < r_min) begin
                    n_min = r_key;
                end
                if (r_key > r_max) begin
                    n_max = r_key;
                end
            end
        end
        if (i_cmd.pop_max) begin
            n_count = r_count - CW'(1);
        end
        if (i_cmd.pop_min) begin
            n_count = r_count - CW'(1);
            n_head  = f_next(r_head);
        end
        if (i_cmd.take_max) begin
            n_max = r_rd_data;
        end
        if (i_cmd.take_min) begin
            n_min = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
        r_pos <= n_pos;
        r_j   <= n_j;
        r_key <= n_key;
        r_min <= n_min;
        r_max <= n_max;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    always_comb begin
        o_status.full      = (r_count == CW'(CAPACITY));
        o_status.empty     = (r_count == '0);
        o_status.one       = (r_count == CW'(1));
        o_status.j_zero    = (r_j == '0);
        o_status.rd_gt_key = (r_rd_data > r_key);

        o_result.is_empty       = (r_count == '0);
        o_result.max_value      = (r_count == '0) ? '0 : 32'(r_max);
        o_result.min_value      = (r_count == '0) ? '0 : 32'(r_min);
        o_result.insert_dropped = r_dropped;
        o_result.entry_count    = 7'(r_count);
    end

endmodule
`default_nettype wire

[design/dep_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dep_controller: sequencer of the priority queue
// Accepts a request, steps the datapath through the insert walk or the
// removal fetch, and raises the done strobe for one cycle.
// ----------------------------------------------------------------------------
module dep_controller (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    input  wire [1:0]            i_cmd_code,
    input  dep_pkg::t_dp_status  i_status,
    output dep_pkg::t_dp_cmd     o_cmd,
    output logic                 busy,
    output logic                 o_done
);
    import dep_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS_CHECK,
        S_INS_CMP,
        S_POP_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;
    logic   r_pop_max, n_pop_max;

    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_pop_max = r_pop_max;
        o_cmd     = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (i_cmd_code)
                        CMD_INSERT: begin
                            if (i_status.full) begin
                                o_cmd.drop = 1'b1;
                                n_done     = 1'b1;
                            end else begin
                                n_state = S_INS_CHECK;
                            end
                        end
                        CMD_REMOVE_MAX: begin
                            if (i_status.empty) begin
                                n_done = 1'b1;
                            end else begin
                                o_cmd.pop_max = 1'b1;
                                if (i_status.one) begin
                                    n_done = 1'b1;
                                end else begin
                                    n_pop_max = 1'b1;
                                    n_state   = S_POP_WAIT;
                                end
                            end
                        end
                        CMD_REMOVE_MIN: begin
                            if (i_status.empty) begin
                                n_done = 1'b1;
                            end else begin
                                o_cmd.pop_min = 1'b1;
                                if (i_status.one) begin
                                    n_done = 1'b1;
                                end else begin
                                    n_pop_max = 1'b0;
                                    n_state   = S_POP_WAIT;
                                end
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_CHECK: begin
                if (i_status.j_zero) begin
                    o_cmd.place = 1'b1;
                    n_done      = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_status.rd_gt_key) begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_INS_CHECK;
                end else begin
                    o_cmd.place = 1'b1;
                    n_done      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_POP_WAIT: begin
                o_cmd.take_max = r_pop_max;
                o_cmd.take_min = !r_pop_max;
                n_done         = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_pop_max <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_pop_max <= n_pop_max;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule
`default_nettype wire

[design/double_ended_priority_queue.sv]
`default_nettype none
// A refused insert, a removal from an empty store, a removal that empties the
// store or the unused command finishes from idle; other removals add a fetch
// state. An insert walks down past every entry larger than the value and stops
// at the bottom or at the first entry that is not larger. One request is in
// flight at a time, so the insert walk sets the throughput; results cannot be
// stalled. Reset empties the store at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// double_ended_priority_queue: bounded sorted multiset of signed values
// Each request inserts a value, removes the largest entry or removes the
// smallest entry. Every request produces one result that reports the
// current maximum and minimum, an empty flag, a refused-insert flag and the
// entry count.
// ----------------------------------------------------------------------------
module double_ended_priority_queue #(
    parameter int CAPACITY    = dep_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = dep_pkg::VALUE_WIDTH_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  dep_pkg::t_item   i_item,
    output logic             o_result_valid,
    output dep_pkg::t_result o_result
);
    import dep_pkg::*;

    // The entries live in ascending order in a circular memory inside the
    // datapath. The head pointer names the minimum, so removing the minimum
    // only advances the head, and removing the maximum only shrinks the
    // count. The new extreme is then fetched with one registered read.
    //
    // An insert starts at the free slot above the maximum and walks down:
    // each step reads the entry below, and if that entry is larger it is
    // copied one place up; otherwise the new value lands in the open slot.
    // Equal values stop the walk, so duplicates stay as separate entries.
    //
    // An insert into a full store leaves the store unchanged and flags the
    // refusal in the result of that request.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    dep_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd_code (i_item.cmd),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .busy       (busy),
        .o_done     (o_result_valid)
    );

    // The datapath holds the result fields in registers, which are stable
    // for the whole cycle in which the done strobe is high.
    dep_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

[tb/double_ended_priority_queue_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_priority_queue_tb: self-checking bench for the priority queue
// Drives insert, remove-maximum, remove-minimum and unused-code requests.
// A behavioral sorted store predicts every result, and each one is checked
// field by field. Directed corner cases come first. Random fill and drain
// sequences follow, and they push the store to full and back to empty.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_tb;

    import dep_pkg::*;

    localparam int         STORE_DEPTH   = CAPACITY_DEF;
    // The fourth command code does nothing; the result just shows the store.
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    // Longest insert walks below all 63 entries of a store one short of full.
    localparam int         WORST_LATENCY = 2 + 2 * (STORE_DEPTH - 1);
    // No handshake for this many cycles means the block has hung.
    localparam int         HANG_LIMIT    = 4000;
    localparam int         RANDOM_PER_PHASE = 150;

    // ------------------------------------------------------------------------
    // Sorted store model and result checker.
    // The store is kept in ascending order. Each accepted request updates it
    // at once, and the result that request must produce is queued. Results
    // are matched in order against that queue.
    // ------------------------------------------------------------------------
    class sorted_store_checker;
        logic signed [31:0] entries[$];
        t_result            pending_results[$];
        int                 errors;
        int                 n_requests;
        int                 n_dropped;
        int                 n_empty_removals;
        int                 n_full_reached;

        function int held();
            return entries.size();
        endfunction

        // Apply one accepted request to the model and queue its result.
        function void note_request(t_item req);
            t_result want;
            int      pos;
            want = '0;
            n_requests++;
            case (req.cmd)
                CMD_INSERT: begin
                    if (entries.size() >= STORE_DEPTH) begin
                        want.insert_dropped = 1'b1;
                        n_dropped++;
                    end else begin
                        // Equal values land above the ones already held.
                        pos = entries.size();
                        while (pos > 0 && $signed(entries[pos - 1]) > $signed(req.value))
                            pos--;
                        entries.insert(pos, req.value);
                        if (entries.size() == STORE_DEPTH)
                            n_full_reached++;
                    end
                end
                CMD_REMOVE_MAX: begin
                    if (entries.size() > 0)
                        entries.delete(entries.size() - 1);
                    else
                        n_empty_removals++;
                end
                CMD_REMOVE_MIN: begin
                    if (entries.size() > 0)
                        entries.delete(0);
                    else
                        n_empty_removals++;
                end
                default: begin
                end
            endcase
            if (entries.size() == 0) begin
                want.is_empty = 1'b1;
            end else begin
                want.max_value = entries[entries.size() - 1];
                want.min_value = entries[0];
            end
            want.entry_count = 7'(entries.size());
            pending_results.insert(pending_results.size(), want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Match one result from the block against the oldest prediction.
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request outstanding: expected none, actual %p",
                         $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("max_value", want.max_value, got.max_value);
            compare_field("min_value", want.min_value, got.min_value);
            compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            compare_field("insert_dropped", 32'(want.insert_dropped), 32'(got.insert_dropped));
            compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_result_valid;
    t_result o_result;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    double_ended_priority_queue i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    sorted_store_checker store_chk = new();

    int   sender_idle_pct = 0;
    int   quiet_cycles    = 0;
    // Direction of the random traffic: filling toward full or draining.
    logic filling         = 1'b1;

    // ------------------------------------------------------------------------
    // Result monitor.
    // The receiver cannot stall, so every strobed cycle is one accepted
    // result. Inputs and outputs are read at the edge, before the block's
    // registers move, so the samples do not depend on event order.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            store_chk.check_result(o_result);
    end

    // Watchdog: counts cycles in which neither a request nor a result is
    // accepted. A correct block never goes this long without one.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, giving up", $time, HANG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request driver.
    // Idle cycles come before the request at random. Then start stays high
    // until an edge finds busy low. start is not dropped after acceptance:
    // the next call either keeps it high with a new request or idles, so it
    // gets only one assignment per edge.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] value);
        t_item req;
        req.cmd   = cmd;
        req.value = value;
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= req;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        store_chk.note_request(req);
    endtask

    // Values mix full-range noise with a narrow band that makes duplicates
    // and with the two extremes of the signed range.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return 32'($signed($urandom_range(8)) - 4);
            7:          return 32'h7FFF_FFFF;
            8:          return 32'h8000_0000;
            default:    return 32'h7FFF_FFFF - 32'($urandom_range(3));
        endcase
    endfunction

    // Random traffic swings between filling and draining. When the store is
    // full it lingers a little, so inserts get refused. When the store is
    // empty it also lingers, so removals on an empty store show up.
    task automatic send_random_request();
        int          roll;
        logic [1:0]  cmd;
        if (filling && store_chk.held() == STORE_DEPTH && $urandom_range(3) == 0)
            filling = 1'b0;
        else if (!filling && store_chk.held() == 0 && $urandom_range(3) == 0)
            filling = 1'b1;
        roll = $urandom_range(99);
        if (roll < 3)
            cmd = CMD_UNUSED;
        else if ((roll < 88) == filling)
            cmd = CMD_INSERT;
        else
            cmd = $urandom_range(1) ? CMD_REMOVE_MAX : CMD_REMOVE_MIN;
        send_request(cmd, pick_value());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The directed part runs with the first idle setting.
        sender_idle_pct = 27;

        // Removals and the unused code on an empty store.
        send_request(CMD_REMOVE_MAX, 32'd0);
        send_request(CMD_REMOVE_MIN, 32'hFFFF_FFFF);
        send_request(CMD_UNUSED, 32'h1234_5678);

        // Extremes of the value range, zero, minus one and duplicates.
        send_request(CMD_INSERT, 32'd0);
        send_request(CMD_INSERT, 32'h7FFF_FFFF);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_INSERT, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'd1);
        send_request(CMD_INSERT, 32'd1);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF);

        // Pull entries from both ends until the store is empty, then once more.
        send_request(CMD_REMOVE_MAX, 32'h7FFF_FFFF);
        send_request(CMD_REMOVE_MIN, 32'd0);
        send_request(CMD_REMOVE_MIN, 32'd0);
        send_request(CMD_REMOVE_MAX, 32'd0);
        send_request(CMD_REMOVE_MAX, 32'd0);
        send_request(CMD_REMOVE_MIN, 32'd0);
        send_request(CMD_REMOVE_MAX, 32'd0);
        send_request(CMD_REMOVE_MIN, 32'd0);

        // A single entry: it is both the maximum and the minimum.
        send_request(CMD_INSERT, 32'hFFFF_FFF0);
        send_request(CMD_REMOVE_MIN, 32'd0);

        // The random part runs in three idle settings: a light sender gap,
        // a heavy sender gap, and then back to back.
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 86 : 0;
            repeat (RANDOM_PER_PHASE)
                send_random_request();
        end
        start <= 1'b0;

        // Drain the outstanding results, then leave room for a stray one.
        while (store_chk.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (WORST_LATENCY) @(posedge i_clk);

        $display("Ran %0d requests: store filled %0d times, %0d inserts refused,",
                 store_chk.n_requests, store_chk.n_full_reached, store_chk.n_dropped);
        $display("%0d removals on an empty store, %0d mismatches.",
                 store_chk.n_empty_removals, store_chk.errors);
        if (store_chk.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
